FILE: rtl/bounded_lifo_stack_assert.svh
// ----------------------------------------------------------------------------
// bounded_lifo_stack_assert.svh
// Assertion macros shared by the stack checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIFO_STACK_ASSERT_SVH
`define BOUNDED_LIFO_STACK_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted (active low)
`define BLSK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define BLSK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/blsk_pkg.sv
// ----------------------------------------------------------------------------
// blsk_pkg
// Types and constants of the bounded LIFO stack.
// ----------------------------------------------------------------------------
package blsk_pkg;

    localparam int WORD_W = 32;
    localparam int CAP_W  = 6;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Word returned by pop, peek or dump on an empty stack
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd999;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_DUMP = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_action                    action;
        logic signed [WORD_W-1:0]   value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0]   data;
        t_status                    status;
        logic                       is_full;
        logic                       is_empty;
        logic                       last;
    } t_out_item;

    // Memory strobes from the controller
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

FILE: rtl/blsk_mem.sv
// ----------------------------------------------------------------------------
// blsk_mem
// Single-port entry store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module blsk_mem #(
    parameter int DEPTH = 32
) (
    input  logic                                i_clk,
    input  blsk_pkg::t_mem_ctl                  i_ctl,
    input  logic [$clog2(DEPTH)-1:0]            i_addr,
    input  logic signed [blsk_pkg::WORD_W-1:0]  i_wdata,
    output logic signed [blsk_pkg::WORD_W-1:0]  o_rdata
);
    import blsk_pkg::*;

    logic signed [WORD_W-1:0] r_mem [DEPTH];
    logic signed [WORD_W-1:0] r_rdata;

    // Write and read; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/blsk_ctrl.sv
// ----------------------------------------------------------------------------
// blsk_ctrl
// Stack controller: entry count, memory sequencing and the output register.
// ----------------------------------------------------------------------------
module blsk_ctrl #(
    parameter int DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [blsk_pkg::CAP_W-1:0]          i_cap,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  blsk_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output blsk_pkg::t_out_item                 o_out,
    output blsk_pkg::t_mem_ctl                  o_mem_ctl,
    output logic [$clog2(DEPTH)-1:0]            o_mem_addr,
    output logic signed [blsk_pkg::WORD_W-1:0]  o_mem_wdata,
    input  logic signed [blsk_pkg::WORD_W-1:0]  i_mem_rdata
);
    import blsk_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // Compare width: holds DEPTH and any capacity code
    localparam int XW = (CW > CAP_W) ? CW + 1 : CAP_W + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state             r_state, n_state;
    t_action            r_op, n_op;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [XW-1:0]      eff_cap;
    logic [CW-1:0]      count_m1;
    logic               out_free;
    logic               accept;
    logic               idx_last;

    function automatic logic f_full(input logic [CW-1:0] cnt, input logic [XW-1:0] cap);
        return XW'(cnt) >= cap;
    endfunction

    // Effective capacity saturates at the built depth
    always_comb begin
        eff_cap = XW'(i_cap);
        if (eff_cap > DEPTH_X) begin
            eff_cap = DEPTH_X;
        end
    end

    assign count_m1   = r_count - CW'(1);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign idx_last   = (CW'(r_idx) + CW'(1)) == r_count;

    // Next state. Writes happen only on push acceptance and reads only in
    // other cycles, so an entry is never written and read in the same cycle.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_mem_ctl   = '0;
        o_mem_addr  = '0;
        o_mem_wdata = i_in.value;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out.data     = EMPTY_WORD;
                    n_out.status   = ST_EMPTY;
                    n_out.is_full  = f_full(r_count, eff_cap);
                    n_out.is_empty = (r_count == '0);
                    n_out.last     = 1'b1;
                    unique case (i_in.action)
                        ACT_PUSH: begin
                            n_out.data = '0;
                            if (XW'(r_count) < eff_cap) begin
                                o_mem_ctl.wr_en = 1'b1;
                                o_mem_addr      = r_count[AW-1:0];
                                n_count         = r_count + CW'(1);
                                n_out.status    = ST_OK;
                                n_out.is_full   = f_full(n_count, eff_cap);
                                n_out.is_empty  = 1'b0;
                            end else begin
                                n_out.status = ST_FULL;
                            end
                        end
                        ACT_POP, ACT_PEEK: begin
                            if (r_count != '0) begin
                                n_out_valid     = r_out_valid && i_out_stall;
                                o_mem_ctl.rd_en = 1'b1;
                                o_mem_addr      = count_m1[AW-1:0];
                                n_op            = i_in.action;
                                n_state         = S_READ;
                            end
                        end
                        ACT_DUMP: begin
                            if (r_count != '0) begin
                                n_out_valid     = r_out_valid && i_out_stall;
                                o_mem_ctl.rd_en = 1'b1;
                                o_mem_addr      = '0;
                                n_idx           = '0;
                                n_op            = ACT_DUMP;
                                n_state         = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                // Read data waits in the memory register until the output frees
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.data   = i_mem_rdata;
                    n_out.status = ST_OK;
                    if (r_op == ACT_POP) begin
                        n_count = count_m1;
                    end
                    n_out.is_full  = f_full(n_count, eff_cap);
                    n_out.is_empty = (n_count == '0);
                    n_out.last     = (r_op != ACT_DUMP) || idx_last;
                    if (r_op == ACT_DUMP && !idx_last) begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_mem_addr      = r_idx + AW'(1);
                        n_idx           = r_idx + AW'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_op  <= n_op;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/bounded_lifo_stack.sv
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded LIFO stack of signed 32-bit words with push, pop, peek and dump.
// ----------------------------------------------------------------------------
// Sequencing: a push, and any action that finds the stack empty, loads the
// output register directly; pop and peek first do the synchronous read of
// the entry memory and then load the output register; a dump does one
// memory read per stored word. The next item is taken as soon as the
// controller is idle and the output register is free or being drained in
// the same cycle. The entry memory is not cleared at reset; only entries
// below the count are ever read. Capacity must be written on the config
// port (always ready) only while the stack is idle, which the block itself
// does not enforce; values above DEPTH behave as DEPTH and zero rejects every push.
module bounded_lifo_stack #(
    parameter int DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [blsk_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  blsk_pkg::t_in_item          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output blsk_pkg::t_out_item         o_out
);
    import blsk_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [CAP_W-1:0]           r_cap;
    t_mem_ctl                   mem_ctl;
    logic [AW-1:0]              mem_addr;
    logic signed [WORD_W-1:0]   mem_wdata;
    logic signed [WORD_W-1:0]   mem_rdata;

    // Capacity register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    blsk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_mem_ctl   (mem_ctl),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    blsk_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: rtl/blsk_chk.sv
// ----------------------------------------------------------------------------
// blsk_chk
// Port-level checks of the bounded LIFO stack, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_lifo_stack_assert.svh"

module blsk_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  blsk_pkg::t_out_item         o_out
);
    import blsk_pkg::*;

    // A rejected push leaves the stack full
    `BLSK_ASSERT(a_full_flag, i_clk, i_rst_n, (o_out_valid && o_out.status == ST_FULL) |-> (o_out.is_full && o_out.last), "rejected push without full flag")

    // Empty result: sentinel word, empty flag, single transfer
    `BLSK_ASSERT(a_empty_res, i_clk, i_rst_n, (o_out_valid && o_out.status == ST_EMPTY) |-> (o_out.data == EMPTY_WORD && o_out.is_empty && o_out.last), "bad empty result")

    // A stalled result holds
    `BLSK_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)), "stalled result changed")

    // No result right after reset
    `BLSK_ASSERT_ALWAYS(a_rst_idle, i_clk, !$past(i_rst_n) |-> !o_out_valid, "result valid after reset")

endmodule

bind bounded_lifo_stack blsk_chk u_blsk_chk (.*);
